FILE: design/blink_code_led_identifier_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the blink code LED identifier.
// ----------------------------------------------------------------------------
`ifndef BLINK_CODE_LED_IDENTIFIER_ASSERT_SVH
`define BLINK_CODE_LED_IDENTIFIER_ASSERT_SVH

// implication checked on the same edge
`define BCL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcl check failed");

// implication checked on the next edge
`define BCL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcl check failed");

`endif

FILE: design/bcl_pkg.sv
// ----------------------------------------------------------------------------
// bcl_pkg
// Types and constants of the blink code LED identifier.
// ----------------------------------------------------------------------------
`default_nettype none
package bcl_pkg;
	localparam int PHASES = 10;
	localparam logic [1:0] ACT_OBSERVE = 2'd0;
	localparam logic [1:0] ACT_WRITE   = 2'd1;
	localparam logic [1:0] ACT_CLEAR   = 2'd2;
	localparam logic [3:0] NO_PHASE    = 4'd15;
	localparam logic signed [6:0] NO_ID = -7'sd1;
	localparam logic [2:0] ST_FIRST   = 3'd0;
	localparam logic [2:0] ST_GAP     = 3'd1;
	localparam logic [2:0] ST_STORED  = 3'd2;
	localparam logic [2:0] ST_HELD    = 3'd3;
	localparam logic [2:0] ST_MATCHED = 3'd4;
	localparam logic [2:0] ST_NOMATCH = 3'd5;
	localparam logic [15:0] MIN_AREA  = 16'd5;
	localparam logic [15:0] MIN_AGE   = 16'd10;
	localparam logic [4:0]  REP_LIMIT = 5'd30;
	localparam logic [4:0]  REP_MAX   = 5'd31;

	typedef struct packed {
		logic [3:0]        last_phase;
		logic [9:0]        stored_code;
		logic [4:0]        repeat_count;
		logic signed [6:0] led_id;
	} slot_rec_t;

	localparam slot_rec_t SLOT_RESET = '{NO_PHASE, 10'd0, 5'd0, NO_ID};

	function automatic logic [3:0] mod10(input logic [7:0] v);
		logic [4:0] q;
		logic [15:0] prod;
		logic [7:0] r;
		begin
			prod = 16'(v) * 16'd205;
			q = prod[15:11];
			r = v - 8'(q) * 8'd10;
			if (r >= 8'd10)
				r = r - 8'd10;
			mod10 = r[3:0];
		end
	endfunction
endpackage
`default_nettype wire

FILE: design/bcl_ram.sv
// ----------------------------------------------------------------------------
// bcl_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bcl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: design/blink_code_led_identifier.sv
// ----------------------------------------------------------------------------
// blink_code_led_identifier
// Identifies blinking LEDs from per-frame blob brightness samples.
// ----------------------------------------------------------------------------
// One item at a time. A table write or ignored item is done as it is taken;
// a clear reads the slot record, clears its ten samples, then writes back
// and gives its result; a first sight, phase gap or young track reads the
// slot record, then writes back and gives its result; an observation that
// forms a code goes through slot record read, ten sample reads, threshold
// and code, write back and result, with a search of the code table, one
// entry per cycle, when the code is needed. A result that is not yet taken
// holds the next item in its result step. Memories hold undefined data after
// reset, so a clearing pass over all sample entries and slot records runs
// first while no item is taken. The code table is not cleared.
`default_nettype none
module blink_code_led_identifier
	import bcl_pkg::*;
#(
	parameter int MAX_SLOTS = 64,
	parameter int MAX_LEDS  = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [6:0]        cfg_data,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire  [1:0]        action,
	input  wire  [5:0]        blob_slot,
	input  wire  [7:0]        frame_phase,
	input  wire  [15:0]       track_age,
	input  wire  [15:0]       blob_area,
	input  wire  [5:0]        led_index,
	input  wire  [9:0]        led_code,
	output logic              out_valid,
	input  wire               out_stall,
	output logic [5:0]        slot_out,
	output logic signed [6:0] led_id,
	output logic [9:0]        code_out,
	output logic              id_changed,
	output logic [2:0]        status
);
	`include "blink_code_led_identifier_assert.svh"

	localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int LW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int SD  = MAX_SLOTS * PHASES;
	localparam int SAW = $clog2(SD);
	localparam int RW  = $bits(slot_rec_t);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_RD, S_DEC, S_SCAN, S_SEARCH, S_TBL, S_WB, S_OUT
	} state_t;

	state_t state_q;
	logic [SAW-1:0] init_q;
	logic [6:0] led_count_q;

	logic [1:0]  act_q;
	logic [SW-1:0] slot_q;
	logic [3:0]  phase_q;
	logic [15:0] age_q, area_q;
	logic [5:0]  slot6_q;
	slot_rec_t   rec_q;
	logic [3:0]  pidx_q;
	logic        rd_vld_q;
	logic [3:0]  rd_p_q;
	logic [15:0] samp_q [PHASES];
	logic [15:0] mn_q, mx_q;
	logic [9:0]  code_q;
	logic [LW:0] tidx_q;
	logic [LW-1:0] rd_t_q;

	logic [5:0]        res_slot_q;
	logic signed [6:0] res_id_q;
	logic [9:0]        res_code_q;
	logic              res_chg_q;
	logic [2:0]        res_st_q;

	// slot record memory
	logic rec_we;
	logic [SW-1:0] rec_waddr;
	slot_rec_t rec_wdata, rec_rdata;
	logic [RW-1:0] rec_rraw;
	bcl_ram #(.WIDTH(RW), .DEPTH(MAX_SLOTS)) u_rec (
		.clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.raddr(slot_q), .rdata(rec_rraw)
	);
	assign rec_rdata = slot_rec_t'(rec_rraw);

	// sample memory
	logic smp_we;
	logic [SAW-1:0] smp_waddr, smp_raddr;
	logic [15:0] smp_wdata, smp_rdata;
	bcl_ram #(.WIDTH(16), .DEPTH(SD)) u_smp (
		.clk(clk), .we(smp_we), .waddr(smp_waddr), .wdata(smp_wdata),
		.raddr(smp_raddr), .rdata(smp_rdata)
	);

	logic in_acc;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign cfg_ready = (state_q == S_IDLE);

	// code table memory, searched one entry per cycle
	logic tbl_we;
	logic [LW-1:0] tbl_waddr;
	logic [9:0] tbl_rdata;
	assign tbl_we = in_acc && action == ACT_WRITE && 32'(led_index) < MAX_LEDS;
	assign tbl_waddr = LW'(led_index);
	bcl_ram #(.WIDTH(10), .DEPTH(MAX_LEDS)) u_tbl (
		.clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(led_code),
		.raddr(tidx_q[LW-1:0]), .rdata(tbl_rdata)
	);

	logic [SAW-1:0] base;
	assign base = SAW'(slot_q) * SAW'(PHASES);
	assign smp_raddr = base + SAW'(pidx_q);

	logic [15:0] thr;
	assign thr = mn_q + ((mx_q - mn_q) >> 1);

	logic [LW:0] ncmp;
	assign ncmp = (32'(led_count_q) < MAX_LEDS) ? (LW+1)'(led_count_q) : (LW+1)'(MAX_LEDS);

	always_comb begin
		rec_we = 1'b0;
		rec_waddr = slot_q;
		rec_wdata = rec_q;
		smp_we = 1'b0;
		smp_waddr = base + SAW'(pidx_q);
		smp_wdata = 16'd0;
		unique case (state_q)
			S_INIT: begin
				smp_we = 1'b1;
				smp_waddr = init_q;
				rec_we = (32'(init_q) < MAX_SLOTS);
				rec_waddr = SW'(init_q);
				rec_wdata = SLOT_RESET;
			end
			S_SCAN: begin
				smp_we = (act_q == ACT_CLEAR);
			end
			S_WB: begin
				rec_we = 1'b1;
				rec_wdata = rec_q;
				smp_we = (act_q == ACT_OBSERVE) && (res_st_q == ST_STORED
					|| res_st_q == ST_HELD || res_st_q == ST_MATCHED
					|| res_st_q == ST_NOMATCH);
				smp_waddr = base + SAW'(phase_q);
				smp_wdata = area_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q <= '0;
			led_count_q <= 7'd0;
			out_valid <= 1'b0;
			act_q <= ACT_OBSERVE;
			slot_q <= '0;
			slot6_q <= '0;
			phase_q <= '0;
			age_q <= '0;
			area_q <= '0;
			rec_q <= SLOT_RESET;
			pidx_q <= '0;
			rd_vld_q <= 1'b0;
			rd_p_q <= '0;
			mn_q <= '0;
			mx_q <= '0;
			code_q <= '0;
			tidx_q <= '0;
			rd_t_q <= '0;
			res_slot_q <= '0;
			res_id_q <= NO_ID;
			res_code_q <= '0;
			res_chg_q <= 1'b0;
			res_st_q <= ST_FIRST;
			slot_out <= '0;
			led_id <= NO_ID;
			code_out <= '0;
			id_changed <= 1'b0;
			status <= ST_FIRST;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			if (cfg_valid && cfg_ready)
				led_count_q <= cfg_data;
			unique case (state_q)
				S_INIT: begin
					init_q <= init_q + SAW'(1);
					if (32'(init_q) == SD - 1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_acc) begin
						act_q <= action;
						slot_q <= SW'(blob_slot);
						slot6_q <= blob_slot;
						phase_q <= mod10(frame_phase);
						age_q <= track_age;
						area_q <= blob_area;
						pidx_q <= '0;
						rd_vld_q <= 1'b0;
						if ((action == ACT_OBSERVE || action == ACT_CLEAR)
							&& 32'(blob_slot) < MAX_SLOTS)
							state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_DEC;
				S_DEC: begin
					rec_q <= rec_rdata;
					res_slot_q <= slot6_q;
					res_code_q <= 10'd0;
					res_chg_q <= 1'b0;
					res_id_q <= rec_rdata.led_id;
					mn_q <= 16'hFFFF;
					mx_q <= 16'd0;
					if (act_q == ACT_CLEAR) begin
						res_chg_q <= (rec_rdata.led_id != NO_ID);
						res_id_q <= NO_ID;
						res_st_q <= ST_NOMATCH;
						rec_q <= SLOT_RESET;
						state_q <= S_SCAN;
					end else if (age_q == 16'd0 || rec_rdata.last_phase == NO_PHASE) begin
						rec_q.last_phase <= phase_q;
						res_st_q <= ST_FIRST;
						state_q <= S_WB;
					end else if (signed'({1'b0, phase_q}) - signed'({1'b0, rec_rdata.last_phase})
						> 5'sd2) begin
						rec_q.last_phase <= phase_q;
						res_st_q <= ST_GAP;
						state_q <= S_WB;
					end else begin
						rec_q.last_phase <= phase_q;
						res_st_q <= ST_STORED;
						state_q <= (age_q < MIN_AGE) ? S_WB : S_SCAN;
					end
				end
				S_SCAN: begin
					logic [15:0] v;
					// issue reads 0..9, capture each in the cycle after its read
					v = (rd_p_q == phase_q) ? area_q : smp_rdata;
					if (pidx_q != 4'(PHASES))
						pidx_q <= pidx_q + 4'd1;
					rd_vld_q <= (pidx_q != 4'(PHASES));
					rd_p_q <= pidx_q;
					if (rd_vld_q) begin
						samp_q[rd_p_q] <= v;
						if (v > mx_q) mx_q <= v;
						if (v < mn_q) mn_q <= v;
					end
					if (act_q == ACT_CLEAR && pidx_q == 4'(PHASES - 1))
						state_q <= S_WB;
					if (act_q == ACT_OBSERVE && rd_vld_q && rd_p_q == 4'(PHASES - 1)) begin
						pidx_q <= '0;
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					logic [9:0] code;
					logic [4:0] rc;
					code = '0;
					for (int p = 0; p < PHASES; p++)
						code[p] = samp_q[p] > thr;
					rc = (rec_q.stored_code == code_q)
						? ((rec_q.repeat_count < REP_MAX) ? rec_q.repeat_count + 5'd1
							: rec_q.repeat_count)
						: 5'd0;
					if (pidx_q == 4'd0) begin
						if (mn_q < MIN_AREA) begin
							res_st_q <= ST_STORED;
							state_q <= S_WB;
						end else begin
							code_q <= code;
							pidx_q <= 4'd1;
						end
					end else begin
						rec_q.repeat_count <= rc;
						res_code_q <= code_q;
						if (!(rec_q.led_id == NO_ID || rc > REP_LIMIT)) begin
							res_st_q <= ST_HELD;
							state_q <= S_WB;
						end else begin
							rec_q.stored_code <= code_q;
							if (code_q == 10'd0) begin
								rec_q.led_id <= NO_ID;
								res_id_q <= NO_ID;
								res_chg_q <= (rec_q.led_id != NO_ID);
								res_st_q <= ST_NOMATCH;
								state_q <= S_WB;
							end else begin
								tidx_q <= '0;
								rd_vld_q <= 1'b0;
								state_q <= S_TBL;
							end
						end
					end
				end
				S_TBL: begin
					if (tidx_q != ncmp)
						tidx_q <= tidx_q + (LW+1)'(1);
					rd_vld_q <= (tidx_q != ncmp);
					rd_t_q <= tidx_q[LW-1:0];
					if (rd_vld_q && tbl_rdata == code_q) begin
						rec_q.led_id <= 7'(rd_t_q);
						res_id_q <= 7'(rd_t_q);
						res_chg_q <= (rec_q.led_id != 7'(rd_t_q));
						res_st_q <= ST_MATCHED;
						state_q <= S_WB;
					end else if (!rd_vld_q && tidx_q == ncmp) begin
						res_st_q <= ST_NOMATCH;
						state_q <= S_WB;
					end
				end
				S_WB: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						slot_out <= res_slot_q;
						led_id <= res_id_q;
						code_out <= res_code_q;
						id_changed <= res_chg_q;
						status <= res_st_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BCL_ASSERT_IMP(a_no_accept_busy, state_q != S_IDLE, !in_acc)
	`BCL_ASSERT_NXT(a_out_from_out, out_valid && !$past(out_valid) && state_q != S_INIT, $past(state_q) == S_OUT || $past(state_q, 2) == S_OUT)
	`BCL_ASSERT_IMP(a_status_range, out_valid, status <= ST_NOMATCH)
endmodule
`default_nettype wire
